### rtl/core/dma_read_request_generator_unit_macros.svh
// Assertion macros for the DMA read request generator.
// Used by the top level only; no other dependencies.
`ifndef DMA_READ_REQUEST_GENERATOR_UNIT_MACROS_SVH
`define DMA_READ_REQUEST_GENERATOR_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DRRG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drrg: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define DRRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drrg: next-cycle check failed");

`endif

### rtl/core/drrg_pkg.sv
// Shared types and constants for the DMA read request generator.
// No dependencies.
`timescale 1ns / 1ps

package drrg_pkg;

   // Default configuration
   localparam int BUF_COUNT_DEF       = 8;
   localparam int BATCH_BEATS_DEF     = 8;
   localparam int BEAT_BYTES_LOG2_DEF = 6;
   localparam int BUF_BYTES_DEF       = 2097152;
   localparam int FLUSH_TICKS_DEF     = 64;

   // Credit count after reset or flush
   localparam logic [9:0] CREDIT_RESET = 10'd512;

   typedef struct packed {
      logic        addr_valid;
      logic [31:0] addr_word;
      logic        commit_valid;
      logic [31:0] commit_len;
      logic        req_ready;
      logic        release_credit;
      logic        flush;
   } req_item_type;

   typedef struct packed {
      logic        addr_taken;
      logic        commit_taken;
      logic        req_valid;
      logic [39:0] req_addr;
      logic [9:0]  ctx_bytes;
      logic        ctx_last;
      logic [39:0] ctx_meta_addr;
      logic        flushing;
   } rsp_item_type;

   // Input register contents: item plus estimated commit_len / batch bytes
   typedef struct packed {
      logic         valid;
      req_item_type item;
      logic [31:0]  quot;
   } stage_type;

   // Core control state visible to the top level
   typedef struct packed {
      logic issuing;
      logic have_length;
      logic flush_active;
   } status_type;

endpackage

### rtl/core/drrg_if.sv
// Valid/ready channel interfaces for request ticks and result ticks.
// Depends on drrg_pkg for the payload types.
`timescale 1ns / 1ps

interface drrg_req_if;
   import drrg_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface drrg_rsp_if;
   import drrg_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/drrg_in_stage.sv
// Input register of the generator, with the reciprocal multiply that
// estimates commit_len / batch bytes. Depends on drrg_pkg and drrg_if.
`timescale 1ns / 1ps

module drrg_in_stage #(
   parameter int BATCH_BEATS     = drrg_pkg::BATCH_BEATS_DEF,
   parameter int BEAT_BYTES_LOG2 = drrg_pkg::BEAT_BYTES_LOG2_DEF
) (
   input  logic                clock,
   input  logic                reset,
   drrg_req_if.sink            req_ch,
   input  logic                adv,
   output drrg_pkg::stage_type stage
);
   import drrg_pkg::*;

   localparam int          BB_BYTES = BATCH_BEATS << BEAT_BYTES_LOG2;
   // floor(2^32 / batch bytes); the quotient estimate is low by at most one
   localparam logic [32:0] RECIP    = 33'((65'd1 << 32) / 65'(BB_BYTES));

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic [31:0]  quot_ff;
   logic [64:0]  prod;
   logic         accept;

   assign req_ch.ready = !valid_ff || adv;
   assign accept       = req_ch.valid && req_ch.ready;

   // Estimate the quotient of the offered length
   assign prod = {33'd0, req_ch.payload.commit_len} * {32'd0, RECIP};

   // Hold the item until the core advances it
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (adv) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_ch.payload;
         quot_ff <= prod[63:32];
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;
   assign stage.quot  = quot_ff;

endmodule

### rtl/core/drrg_core.sv
// Control state, buffer base table and request computation of the
// generator. Depends on drrg_pkg.
`timescale 1ns / 1ps

module drrg_core #(
   parameter int BUF_COUNT       = drrg_pkg::BUF_COUNT_DEF,
   parameter int BATCH_BEATS     = drrg_pkg::BATCH_BEATS_DEF,
   parameter int BEAT_BYTES_LOG2 = drrg_pkg::BEAT_BYTES_LOG2_DEF,
   parameter int BUF_BYTES       = drrg_pkg::BUF_BYTES_DEF,
   parameter int FLUSH_TICKS     = drrg_pkg::FLUSH_TICKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  drrg_pkg::stage_type    stage,
   input  logic                   adv,
   output drrg_pkg::rsp_item_type res,
   output drrg_pkg::status_type   status
);
   import drrg_pkg::*;

   localparam int             IDX_W    = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;
   localparam int             BB_BYTES = BATCH_BEATS << BEAT_BYTES_LOG2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_COUNT - 1);
   localparam logic [39:0]    BB40     = 40'(BB_BYTES);
   localparam logic [32:0]    BB33     = 33'(BB_BYTES);
   localparam logic [17:0]    BB18     = 18'(BB_BYTES);
   localparam logic [9:0]     BB10     = 10'(BB_BYTES);
   localparam logic [9:0]     BEATS10  = 10'(BATCH_BEATS);
   localparam logic [39:0]    BUF40    = 40'(BUF_BYTES);
   localparam logic [15:0]    FLUSH16  = 16'(FLUSH_TICKS);

   req_item_type it;

   // Control state
   logic             issuing_ff, issuing_in;
   logic             expect_hi_ff, expect_hi_in;
   logic [IDX_W-1:0] store_idx_ff, store_idx_in;
   logic [IDX_W-1:0] cur_buf_ff, cur_buf_in;
   logic             have_len_ff, have_len_in;
   logic [9:0]       credits_ff, credits_in;
   logic             flush_active_ff, flush_active_in;
   logic [15:0]      flush_cnt_ff, flush_cnt_in;

   // Payload state
   logic [7:0]       hi_byte_ff, hi_byte_in;
   logic [39:0]      next_addr_ff, next_addr_in;
   logic [39:0]      cur_base_ff, cur_base_in;
   logic [39:0]      upper_ff, upper_in;
   logic [39:0]      meta_ff, meta_in;
   logic [9:0]       last_bytes_ff, last_bytes_in;

   // Base table
   logic [39:0]      base_mem [BUF_COUNT];
   logic [39:0]      nxt_base_ff;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_en;
   logic [39:0]      wr_base;

   // Working values
   logic             flush_tick;
   logic [15:0]      flush_cnt_nxt;
   logic [9:0]       credits_mid;
   logic [39:0]      adv_addr;
   logic [32:0]      qbb;
   logic [32:0]      rem_est;
   logic [17:0]      rem_fix;
   logic [17:0]      rem_last;

   assign it = stage.item;

   // Table entry after the current buffer, read into a register ahead of its use
   assign rd_idx = (cur_buf_ff == LAST_IDX) ? '0 : cur_buf_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en && adv) begin
         base_mem[store_idx_ff] <= wr_base;
      end
      nxt_base_ff <= base_mem[rd_idx];
   end

   // Size of the closing batch: commit_len mod batch bytes, zero means full
   assign qbb      = {1'b0, stage.quot} * BB33;
   assign rem_est  = {1'b0, it.commit_len} - qbb;
   assign rem_fix  = (rem_est[17:0] >= BB18) ? rem_est[17:0] - BB18 : rem_est[17:0];
   assign rem_last = (rem_fix == 18'd0) ? BB18 : rem_fix;

   assign flush_tick    = flush_active_ff || it.flush;
   assign flush_cnt_nxt = flush_cnt_ff + 16'd1;
   assign adv_addr      = next_addr_ff + BB40;
   assign wr_base       = {hi_byte_ff, it.addr_word};

   // Next state and result for one tick
   always_comb begin
      res             = '0;
      wr_en           = 1'b0;
      issuing_in      = issuing_ff;
      expect_hi_in    = expect_hi_ff;
      store_idx_in    = store_idx_ff;
      cur_buf_in      = cur_buf_ff;
      have_len_in     = have_len_ff;
      credits_mid     = credits_ff;
      credits_in      = credits_ff;
      flush_active_in = flush_active_ff;
      flush_cnt_in    = flush_cnt_ff;
      hi_byte_in      = hi_byte_ff;
      next_addr_in    = next_addr_ff;
      cur_base_in     = cur_base_ff;
      upper_in        = upper_ff;
      meta_in         = meta_ff;
      last_bytes_in   = last_bytes_ff;

      if (flush_tick) begin
         // Drain inputs and clear control state
         res.addr_taken   = it.addr_valid;
         res.commit_taken = it.commit_valid;
         res.flushing     = 1'b1;
         issuing_in       = 1'b0;
         expect_hi_in     = 1'b1;
         store_idx_in     = '0;
         cur_buf_in       = '0;
         have_len_in      = 1'b0;
         credits_in       = CREDIT_RESET;
         if (flush_cnt_nxt == FLUSH16) begin
            flush_cnt_in    = '0;
            flush_active_in = 1'b0;
         end else begin
            flush_cnt_in    = flush_cnt_nxt;
            flush_active_in = 1'b1;
         end
      end else begin
         if (!issuing_ff) begin
            // Pair address words into buffer bases
            if (it.addr_valid) begin
               res.addr_taken = 1'b1;
               expect_hi_in   = !expect_hi_ff;
               if (expect_hi_ff) begin
                  hi_byte_in = it.addr_word[7:0];
               end else begin
                  wr_en        = 1'b1;
                  store_idx_in = store_idx_ff + IDX_W'(1);
                  if (store_idx_ff == '0) begin
                     cur_base_in = wr_base;
                  end
                  if (store_idx_ff == LAST_IDX) begin
                     issuing_in   = 1'b1;
                     next_addr_in = (store_idx_ff == '0) ? wr_base : cur_base_ff;
                  end
               end
            end
         end else if (have_len_ff) begin
            // Issue one batch when credits and downstream allow
            if (credits_ff >= BEATS10 && it.req_ready) begin
               res.req_valid = 1'b1;
               res.req_addr  = next_addr_ff;
               credits_mid   = credits_ff - BEATS10;
               if (adv_addr >= upper_ff) begin
                  res.ctx_bytes     = last_bytes_ff;
                  res.ctx_last      = 1'b1;
                  res.ctx_meta_addr = meta_ff;
                  cur_buf_in        = (cur_buf_ff == LAST_IDX) ? '0 : cur_buf_ff + IDX_W'(1);
                  next_addr_in      = nxt_base_ff;
                  cur_base_in       = nxt_base_ff;
                  have_len_in       = 1'b0;
               end else begin
                  res.ctx_bytes = BB10;
                  next_addr_in  = adv_addr;
               end
            end
         end else if (it.commit_valid) begin
            // Take the length and precompute the buffer end values
            res.commit_taken = 1'b1;
            have_len_in      = 1'b1;
            upper_in         = cur_base_ff + {8'd0, it.commit_len};
            meta_in          = cur_base_ff + BUF40;
            last_bytes_in    = rem_last[9:0];
         end
         credits_in = credits_mid + {9'd0, it.release_credit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff      <= 1'b0;
         expect_hi_ff    <= 1'b1;
         store_idx_ff    <= '0;
         cur_buf_ff      <= '0;
         have_len_ff     <= 1'b0;
         credits_ff      <= CREDIT_RESET;
         flush_active_ff <= 1'b0;
         flush_cnt_ff    <= '0;
      end else if (adv) begin
         issuing_ff      <= issuing_in;
         expect_hi_ff    <= expect_hi_in;
         store_idx_ff    <= store_idx_in;
         cur_buf_ff      <= cur_buf_in;
         have_len_ff     <= have_len_in;
         credits_ff      <= credits_in;
         flush_active_ff <= flush_active_in;
         flush_cnt_ff    <= flush_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hi_byte_ff    <= hi_byte_in;
         next_addr_ff  <= next_addr_in;
         cur_base_ff   <= cur_base_in;
         upper_ff      <= upper_in;
         meta_ff       <= meta_in;
         last_bytes_ff <= last_bytes_in;
      end
   end

   assign status.issuing      = issuing_ff;
   assign status.have_length  = have_len_ff;
   assign status.flush_active = flush_active_ff;

endmodule

### rtl/core/drrg_out_stage.sv
// Result register of the generator, driving the result channel.
// Depends on drrg_pkg and drrg_if.
`timescale 1ns / 1ps

module drrg_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  drrg_pkg::rsp_item_type res,
   output logic                   room,
   drrg_rsp_if.source             rsp_ch
);
   import drrg_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   assign room = !valid_ff || rsp_ch.ready;

   // Hold the result until the sink takes it
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.payload = data_ff;

endmodule

### rtl/core/dma_read_request_generator_unit.sv
// DMA read request generator: one result item per accepted tick item.
// Items go from the input register to the result register on rsp_ch; one
// item per cycle sustained while rsp_ch is not stalled, set by the single
// state-update stage between them. Reset clears control state, sets 512
// credits and leaves the buffer base table undefined until loaded again.
`timescale 1ns / 1ps
`include "dma_read_request_generator_unit_macros.svh"

module dma_read_request_generator_unit #(
   parameter int BUF_COUNT       = drrg_pkg::BUF_COUNT_DEF,
   parameter int BATCH_BEATS     = drrg_pkg::BATCH_BEATS_DEF,
   parameter int BEAT_BYTES_LOG2 = drrg_pkg::BEAT_BYTES_LOG2_DEF,
   parameter int BUF_BYTES       = drrg_pkg::BUF_BYTES_DEF,
   parameter int FLUSH_TICKS     = drrg_pkg::FLUSH_TICKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   drrg_req_if.sink   req_ch,
   drrg_rsp_if.source rsp_ch
);
   import drrg_pkg::*;

   stage_type    stage;
   rsp_item_type res;
   status_type   status;
   logic         room;
   logic         adv;

   // Advance the held item when the result register has room
   assign adv = stage.valid && room;

   drrg_in_stage #(
      .BATCH_BEATS     (BATCH_BEATS),
      .BEAT_BYTES_LOG2 (BEAT_BYTES_LOG2)
   ) u_in (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .adv    (adv),
      .stage  (stage)
   );

   drrg_core #(
      .BUF_COUNT       (BUF_COUNT),
      .BATCH_BEATS     (BATCH_BEATS),
      .BEAT_BYTES_LOG2 (BEAT_BYTES_LOG2),
      .BUF_BYTES       (BUF_BYTES),
      .FLUSH_TICKS     (FLUSH_TICKS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .adv    (adv),
      .res    (res),
      .status (status)
   );

   drrg_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (adv),
      .res    (res),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   // A flush tick leaves the block loading with no held length
   `DRRG_ASSERT_NEXT(a_flush_clears, clock, reset, adv && (status.flush_active || stage.item.flush), !status.issuing && !status.have_length)
   // Requests come only from the issuing phase with a length held
   `DRRG_ASSERT_SAME(a_req_when_issuing, clock, reset, adv && res.req_valid, status.issuing && status.have_length)
   // A full input register behind a stalled result blocks intake
   `DRRG_ASSERT_SAME(a_stall_blocks, clock, reset, stage.valid && rsp_ch.valid && !rsp_ch.ready, !req_ch.ready)

endmodule

### test/dma_read_request_generator_unit_tb.sv
// Self-checking testbench for dma_read_request_generator_unit.
// Drives tick items through drrg_req_if, predicts each result item and checks it on drrg_rsp_if.
// Depends on drrg_pkg, drrg_if.sv and the unit RTL.
`timescale 1ns / 1ps

module dma_read_request_generator_unit_tb;
   import drrg_pkg::*;

   localparam int BUF_COUNT       = BUF_COUNT_DEF;
   localparam int BATCH_BEATS     = BATCH_BEATS_DEF;
   localparam int BEAT_BYTES_LOG2 = BEAT_BYTES_LOG2_DEF;
   localparam int BUF_BYTES       = BUF_BYTES_DEF;
   localparam int FLUSH_TICKS     = FLUSH_TICKS_DEF;
   localparam int BATCH_BYTES     = BATCH_BEATS << BEAT_BYTES_LOG2;
   localparam int IDX_W           = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;
   localparam logic [63:0] ADDR_SPAN = 64'h100_0000_0000;
   localparam int DRAIN_CYCLES    = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drrg_req_if req_ch ();
   drrg_rsp_if rsp_ch ();

   dma_read_request_generator_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow state of the request generator
   logic              gen_issuing;
   logic              gen_expect_hi;
   logic [31:0]       gen_hi_word;
   logic [7:0]        gen_fill_idx;
   logic [39:0]       gen_base [BUF_COUNT];
   logic [7:0]        gen_cur_buf;
   logic              gen_have_len;
   logic [31:0]       gen_len;
   logic [39:0]       gen_next_addr;
   logic [9:0]        gen_credits;
   logic              gen_flushing;
   logic [15:0]       gen_flush_cnt;

   rsp_item_type pending_results [$];
   int           error_count = 0;
   int           sent_count  = 0;
   int           idle_pct    = 0;

   function automatic void clear_control();
      gen_issuing   = 1'b0;
      gen_expect_hi = 1'b1;
      gen_fill_idx  = '0;
      gen_cur_buf   = '0;
      gen_credits   = CREDIT_RESET;
      gen_have_len  = 1'b0;
      gen_len       = '0;
   endfunction

   function automatic void reset_model();
      clear_control();
      gen_hi_word   = '0;
      gen_next_addr = '0;
      gen_flushing  = 1'b0;
      gen_flush_cnt = '0;
      for (int i = 0; i < BUF_COUNT; i++) gen_base[IDX_W'(i)] = '0;
   endfunction

   // Advance the shadow state by one tick item and return its result item
   function automatic rsp_item_type predict_tick_result(input req_item_type t);
      rsp_item_type r;
      logic [7:0]   cb;
      logic [39:0]  base;
      logic [39:0]  upper;
      logic [63:0]  rem;
      r = '0;
      // flush tick: clear control, swallow offers, drop the credit
      if (gen_flushing || t.flush) begin
         gen_flushing = 1'b1;
         clear_control();
         r.addr_taken   = t.addr_valid;
         r.commit_taken = t.commit_valid;
         r.flushing     = 1'b1;
         gen_flush_cnt  = gen_flush_cnt + 16'd1;
         if (gen_flush_cnt == 16'(FLUSH_TICKS)) begin
            gen_flush_cnt = '0;
            gen_flushing  = 1'b0;
         end
         return r;
      end
      if (!gen_issuing) begin
         // pair high and low words into table bases
         if (t.addr_valid) begin
            r.addr_taken = 1'b1;
            if (gen_expect_hi) begin
               gen_hi_word = t.addr_word;
            end else begin
               if (gen_fill_idx < 8'(BUF_COUNT))
                  gen_base[gen_fill_idx[IDX_W-1:0]] = {gen_hi_word[7:0], t.addr_word};
               gen_fill_idx = gen_fill_idx + 8'd1;
               if (gen_fill_idx == 8'(BUF_COUNT)) begin
                  gen_next_addr = gen_base[0];
                  gen_issuing   = 1'b1;
               end
            end
            gen_expect_hi = !gen_expect_hi;
         end
      end else if (gen_have_len) begin
         // issue one batch when credits and downstream allow
         if (gen_credits >= 10'(BATCH_BEATS) && t.req_ready) begin
            cb    = (gen_cur_buf < 8'(BUF_COUNT)) ? gen_cur_buf : 8'd0;
            base  = gen_base[cb[IDX_W-1:0]];
            upper = base + 40'(gen_len);
            r.req_valid   = 1'b1;
            r.req_addr    = gen_next_addr;
            gen_credits   = gen_credits - 10'(BATCH_BEATS);
            gen_next_addr = gen_next_addr + 40'(BATCH_BYTES);
            if (gen_next_addr >= upper) begin
               rem = 64'(gen_len) % 64'(BATCH_BYTES);
               if (rem == 64'd0) rem = 64'(BATCH_BYTES);
               r.ctx_bytes     = rem[9:0];
               r.ctx_last      = 1'b1;
               r.ctx_meta_addr = base + 40'(BUF_BYTES);
               gen_cur_buf     = 8'((cb + 1) % BUF_COUNT);
               gen_next_addr   = gen_base[gen_cur_buf[IDX_W-1:0]];
               gen_have_len    = 1'b0;
            end else begin
               r.ctx_bytes = 10'(BATCH_BYTES);
            end
         end
      end else if (t.commit_valid) begin
         r.commit_taken = 1'b1;
         gen_have_len   = 1'b1;
         gen_len        = t.commit_len;
      end
      gen_credits = gen_credits + 10'(t.release_credit);
      return r;
   endfunction

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic req_item_type make_tick(input logic av, input logic [31:0] aw,
                                              input logic cv, input logic [31:0] cl,
                                              input logic rdy, input logic rel, input logic fl);
      req_item_type t;
      t.addr_valid     = av;
      t.addr_word      = aw;
      t.commit_valid   = cv;
      t.commit_len     = cl;
      t.req_ready      = rdy;
      t.release_credit = rel;
      t.flush          = fl;
      return t;
   endfunction

   // Send one tick item, optionally after an idle burst, and record its result
   task automatic send_tick(input req_item_type t);
      int gap;
      if (idle_pct != 0 && roll(idle_pct)) begin
         gap = $urandom_range(1, 9);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(predict_tick_result(t));
      sent_count++;
   endtask

   // Load all table bases, words given as {high, low}, with ignored ticks mixed in
   task automatic load_table(input logic [63:0] words [BUF_COUNT]);
      for (int i = 0; i < BUF_COUNT; i++) begin
         if (roll(25)) send_tick(make_tick(1'b0, $urandom, roll(50), $urandom, roll(50), roll(50), 1'b0));
         send_tick(make_tick(1'b1, words[IDX_W'(i)][63:32], roll(25), $urandom, roll(50), roll(30),
                             1'b0));
         if (roll(25)) send_tick(make_tick(1'b0, $urandom, roll(50), $urandom, roll(50), roll(50), 1'b0));
         send_tick(make_tick(1'b1, words[IDX_W'(i)][31:0], roll(25), $urandom, roll(50), roll(30),
                             1'b0));
      end
   endtask

   task automatic load_random_table();
      logic [63:0] words [BUF_COUNT];
      logic [39:0] base;
      for (int i = 0; i < BUF_COUNT; i++) begin
         // a quarter of the bases sit just under the top of the address space
         if (roll(25)) base = {8'hFF, 32'hFFFF_F000 | 32'($urandom_range(0, 4095))};
         else base = {8'($urandom), 32'($urandom)};
         words[IDX_W'(i)] = {24'($urandom), base[39:32], base[31:0]};
      end
      load_table(words);
   endtask

   // Commit a length to the current buffer and tick until it ends, or for max_ticks ticks
   task automatic run_buffer(input logic [31:0] len, input int ready_pct, input int release_pct,
                             input int max_ticks);
      logic [39:0] base;
      logic [63:0] reach;
      int          n;
      base  = gen_base[gen_cur_buf[IDX_W-1:0]];
      reach = 64'(base) + 64'(len);
      // keep the batch address from wrapping before it reaches an unwrapped end
      if (max_ticks == 0 && reach < ADDR_SPAN && reach + 64'(BATCH_BYTES) >= ADDR_SPAN)
         len = 32'(ADDR_SPAN - 64'(base));
      while (!gen_have_len)
         send_tick(make_tick(roll(25), $urandom, roll(75), len, roll(ready_pct),
                             roll(release_pct), 1'b0));
      n = 0;
      while (gen_have_len && (max_ticks == 0 || n < max_ticks)) begin
         send_tick(make_tick(roll(25), $urandom, roll(25), $urandom, roll(ready_pct),
                             roll(release_pct), 1'b0));
         n++;
      end
   endtask

   // Start a flush and drain it with random content
   task automatic run_flush();
      send_tick(make_tick(roll(50), $urandom, roll(50), $urandom, roll(50), roll(50), 1'b1));
      while (gen_flushing)
         send_tick(make_tick(roll(50), $urandom, roll(50), $urandom, roll(50), roll(50), roll(30)));
   endtask

   // One load of the table, a run of buffers, then a flush back to loading
   task automatic run_session();
      int          nbuf;
      int          pick;
      bit          cut;
      logic [31:0] len;
      load_random_table();
      nbuf = $urandom_range(3, 12);
      cut  = 1'b0;
      for (int i = 0; i < nbuf && !cut; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) len = $urandom_range(0, 2000);
         else if (pick < 60) len = 32'(BATCH_BYTES * $urandom_range(0, 4));
         else if (pick < 75) len = $urandom_range(1, BATCH_BYTES - 1);
         else if (pick < 90) len = $urandom_range(2000, 12000);
         else if (pick < 95) len = $urandom_range(0, 600);
         else begin
            len = $urandom;
            cut = 1'b1;
         end
         run_buffer(len, $urandom_range(30, 100), $urandom_range(10, 100),
                    cut ? $urandom_range(1, 20) : 0);
      end
      run_flush();
   endtask

   task automatic test_load_extremes();
      logic [63:0] words [BUF_COUNT];
      idle_pct = 10;
      words = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FE00,
                64'hA5A5_A512_3456_7800, 64'h0000_00FF_FFFF_FFFF,
                64'h5A5A_5A00_0000_1000, 64'h0000_005A_C3C3_3C00,
                64'h1234_5680_0000_0000, 64'hFFFF_FF0F_0F0F_0F0F};
      load_table(words);
   endtask

   // Zero length, wrapping sums, exact batch multiples, short tails, round-robin back to 0
   task automatic test_issue_cases();
      run_buffer(32'd0, 100, 0, 0);
      run_buffer(32'd1000, 100, 0, 0);
      run_buffer(32'd700, 40, 20, 0);
      run_buffer(32'd300, 100, 0, 0);
      run_buffer(32'd512, 100, 50, 0);
      run_buffer(32'd1025, 100, 0, 0);
      run_buffer(32'd1536, 70, 50, 0);
      run_buffer(32'd100, 100, 0, 0);
      run_buffer(32'd513, 100, 0, 0);
   endtask

   // Flush mid-buffer, then flush with an unpaired address word
   task automatic test_flush_cases();
      run_buffer(32'hFFFF_FFFF, 100, 50, 4);
      run_flush();
      repeat (3) send_tick(make_tick(1'b1, $urandom, 1'b0, $urandom, 1'b0, 1'b0, 1'b0));
      run_flush();
   endtask

   // Return credits until the count wraps to zero, then reload the table and issue from the credits returned since
   task automatic test_credit_wrap();
      repeat (512) send_tick(make_tick(1'b0, $urandom, roll(50), $urandom, roll(50), 1'b1, 1'b0));
      load_random_table();
      run_buffer(32'd2000, 100, 15, 0);
      run_flush();
   endtask

   task automatic test_random_sessions();
      while (sent_count < 1450) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 15;
            default: idle_pct = 30;
         endcase
         run_session();
      end
   endtask

   task automatic test_steady_stream();
      idle_pct = 0;
      while (sent_count < 1650) run_session();
   endtask

   // Result side: stall in random bursts while idling is on
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (idle_pct != 0 && roll(idle_pct)) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [39:0] want,
                                       input logic [39:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each result item with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no prediction waiting");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("addr_taken", 40'(want.addr_taken), 40'(rsp_ch.payload.addr_taken));
            check_field("commit_taken", 40'(want.commit_taken),
                        40'(rsp_ch.payload.commit_taken));
            check_field("req_valid", 40'(want.req_valid), 40'(rsp_ch.payload.req_valid));
            check_field("req_addr", want.req_addr, rsp_ch.payload.req_addr);
            check_field("ctx_bytes", 40'(want.ctx_bytes), 40'(rsp_ch.payload.ctx_bytes));
            check_field("ctx_last", 40'(want.ctx_last), 40'(rsp_ch.payload.ctx_last));
            check_field("ctx_meta_addr", want.ctx_meta_addr, rsp_ch.payload.ctx_meta_addr);
            check_field("flushing", 40'(want.flushing), 40'(rsp_ch.payload.flushing));
         end
      end
   end

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_load_extremes();
      test_issue_cases();
      test_flush_cases();
      test_credit_wrap();
      test_random_sessions();
      test_steady_stream();
      req_ch.valid <= 1'b0;
      // drain outstanding result items
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("dma_read_request_generator_unit_tb: done, clean");
      end else begin
         $display("dma_read_request_generator_unit_tb: done, errors");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("dma_read_request_generator_unit_tb: done, errors");
      $finish;
   end

endmodule

### dma_read_request_generator_unit.f
+incdir+rtl/core
rtl/core/drrg_pkg.sv
rtl/core/drrg_if.sv
rtl/core/drrg_in_stage.sv
rtl/core/drrg_core.sv
rtl/core/drrg_out_stage.sv
rtl/core/dma_read_request_generator_unit.sv
test/dma_read_request_generator_unit_tb.sv
